// ----- src/jcc_pkg.sv -----
// jcc_pkg: shared types and constants for the joystick center calibration block
// used by jcc_pipe, joystick_center_calibrate_unit and jcc_checker
// no dependencies
package jcc_pkg;

   // field widths and lane count
   localparam int unsigned DATA_W    = 12;
   localparam int unsigned NUM_AXES  = 2;
   localparam int unsigned AXIS_X    = 0;
   localparam int unsigned AXIS_Y    = 1;

   // default output range
   localparam int unsigned FULL_SCALE_DEF = 4095;
   localparam int unsigned OUT_FLOOR_DEF  = 0;

   // floor(a / 100) for a < 4096 is (a * 5243) >> 19
   localparam int unsigned RECIP_W       = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int unsigned RECIP_SHIFT   = 19;
   localparam int unsigned Q100_W        = 6;

   // register file
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_MIN    = 3'd0,
      CSR_X_MAX    = 3'd1,
      CSR_X_CENTER = 3'd2,
      CSR_Y_MIN    = 3'd3,
      CSR_Y_MAX    = 3'd4,
      CSR_Y_CENTER = 3'd5
   } csr_reg_type;

   localparam logic [DATA_W-1:0] MIN_RST    = 12'd1024;
   localparam logic [DATA_W-1:0] MAX_RST    = 12'd3072;
   localparam logic [DATA_W-1:0] CENTER_RST = 12'd2048;

   // calibration of one axis
   typedef struct packed {
      logic [DATA_W-1:0] min;
      logic [DATA_W-1:0] max;
      logic [DATA_W-1:0] center;
   } axis_cfg_type;

endpackage

// ----- src/joystick_center_calibrate_unit.sv -----
// joystick_center_calibrate_unit: top level, calibration registers and output skid
// depends on jcc_pkg and jcc_pipe
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_x_raw, req_y_raw
//   rsp       out         rsp_valid/rsp_stall  rsp_x_norm, rsp_y_norm
//   csr       in          csr_wr_en            csr_index, csr_wr_data
//
// one request per cycle while req_stall is low; the divider resolves one quotient bit per stage
// over a DIV_W-bit quotient, DIV_W = 12 + clog2(FULL_SCALE/2 + 1)
// reset is synchronous and brings the registers to their calibration defaults
// a stalled response parks the next one in a skid slot; req_stall is high while it is full
module joystick_center_calibrate_unit #(
   parameter int unsigned FULL_SCALE = jcc_pkg::FULL_SCALE_DEF,
   parameter int unsigned OUT_FLOOR  = jcc_pkg::OUT_FLOOR_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [jcc_pkg::DATA_W-1:0]       req_x_raw,
   input  logic [jcc_pkg::DATA_W-1:0]       req_y_raw,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [jcc_pkg::DATA_W-1:0]       rsp_x_norm,
   output logic [jcc_pkg::DATA_W-1:0]       rsp_y_norm,
   input  logic                             csr_wr_en,
   input  logic [jcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jcc_pkg::DATA_W-1:0]       csr_wr_data
);
   import jcc_pkg::*;

   axis_cfg_type [NUM_AXES-1:0]         cfg_ff, cfg_in;
   logic [NUM_AXES-1:0][DATA_W-1:0]     raw;
   logic [NUM_AXES-1:0][DATA_W-1:0]     pipe_norm;
   logic                                pipe_valid;
   logic                                pipe_en;
   logic                                take;
   logic                                out_vld_ff, out_vld_in;
   logic                                skid_vld_ff, skid_vld_in;
   logic [NUM_AXES-1:0][DATA_W-1:0]     out_ff, out_in;
   logic [NUM_AXES-1:0][DATA_W-1:0]     skid_ff, skid_in;

   // calibration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_X_MIN:    cfg_in[AXIS_X].min    = csr_wr_data;
            CSR_X_MAX:    cfg_in[AXIS_X].max    = csr_wr_data;
            CSR_X_CENTER: cfg_in[AXIS_X].center = csr_wr_data;
            CSR_Y_MIN:    cfg_in[AXIS_Y].min    = csr_wr_data;
            CSR_Y_MAX:    cfg_in[AXIS_Y].max    = csr_wr_data;
            CSR_Y_CENTER: cfg_in[AXIS_Y].center = csr_wr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            cfg_ff[i].min    <= MIN_RST;
            cfg_ff[i].max    <= MAX_RST;
            cfg_ff[i].center <= CENTER_RST;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scaling pipeline, advances whenever the skid slot is free
   assign raw[AXIS_X] = req_x_raw;
   assign raw[AXIS_Y] = req_y_raw;
   assign pipe_en     = !skid_vld_ff;
   assign req_stall   = skid_vld_ff;

   jcc_pipe #(
      .FULL_SCALE (FULL_SCALE),
      .OUT_FLOOR  (OUT_FLOOR)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_raw    (raw),
      .cfg       (cfg_ff),
      .out_valid (pipe_valid),
      .out_norm  (pipe_norm)
   );

   // output register with skid slot
   assign take = out_vld_ff && !rsp_stall;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_vld_in = pipe_valid;
         out_in     = pipe_norm;
      end else if (pipe_valid) begin
         skid_vld_in = 1'b1;
         skid_in     = pipe_norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_x_norm = out_ff[AXIS_X];
   assign rsp_y_norm = out_ff[AXIS_Y];

endmodule

// ----- src/jcc_pipe.sv -----
// jcc_pipe: per-axis scaling pipeline with a bit-per-stage restoring divider
// depends on jcc_pkg
// all stages move together on en; valid bits travel alongside the data
module jcc_pipe #(
   parameter int unsigned FULL_SCALE = jcc_pkg::FULL_SCALE_DEF,
   parameter int unsigned OUT_FLOOR  = jcc_pkg::OUT_FLOOR_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   en,
   input  logic                                                   in_valid,
   input  logic [jcc_pkg::NUM_AXES-1:0][jcc_pkg::DATA_W-1:0]      in_raw,
   input  jcc_pkg::axis_cfg_type [jcc_pkg::NUM_AXES-1:0]          cfg,
   output logic                                                   out_valid,
   output logic [jcc_pkg::NUM_AXES-1:0][jcc_pkg::DATA_W-1:0]      out_norm
);
   import jcc_pkg::*;

   localparam int unsigned HALF  = FULL_SCALE / 2;
   localparam int unsigned HW    = $clog2(HALF + 1);
   localparam int unsigned DIV_W = DATA_W + HW;
   localparam int unsigned RES_W = DIV_W + 2;
   localparam int unsigned PROD_W = DATA_W + RECIP_W;
   // five front stages, divider setup, DIV_W divider steps, result stage
   localparam int unsigned NSTG  = DIV_W + 7;

   typedef struct packed {
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] mx;
      logic [DATA_W-1:0] mn;
   } st1_type;

   typedef struct packed {
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] mx;
      logic [DATA_W-1:0] mn;
      logic [DATA_W-1:0] ah;
      logic [DATA_W-1:0] al;
      logic              nh;
      logic              nl;
   } st2_type;

   typedef struct packed {
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] mx;
      logic [DATA_W-1:0] mn;
      logic [Q100_W-1:0] qh;
      logic [Q100_W-1:0] ql;
      logic              nh;
      logic              nl;
   } st3_type;

   typedef struct packed {
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
   } st4_type;

   typedef struct packed {
      logic [DATA_W:0]   den;
      logic [DATA_W-1:0] diff;
      logic              up;
      logic              eq;
   } st5_type;

   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DIV_W-1:0]  num;
      logic [DIV_W-1:0]  quo;
      logic [DATA_W-1:0] dmag;
      logic              dneg;
      logic              dz;
      logic              up;
      logic              eq;
   } div_type;

   // valid chain
   logic [NSTG-1:0] vld_ff, vld_in;

   assign vld_in    = {vld_ff[NSTG-2:0], in_valid};
   assign out_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      st1_type           s1_in, s1_ff;
      st2_type           s2_in, s2_ff;
      st3_type           s3_in, s3_ff;
      st4_type           s4_in, s4_ff;
      st5_type           s5_in, s5_ff;
      div_type           dv_in [0:DIV_W];
      div_type           dv_ff [0:DIV_W];
      logic [DATA_W-1:0] res_in, res_ff;
      logic [DATA_W:0]   sum1;
      logic [DATA_W:0]   dh2, dl2;
      logic [PROD_W-1:0] ph3, pl3;
      logic [DATA_W:0]   hi4, lo4;
      logic signed [RES_W-1:0] val_r, clip_r, sel_r;
      logic              neg_r;

      // stage 1: capture sample, center falls back to mid of min and max when it is zero
      always_comb begin
         sum1     = {1'b0, cfg[a].max} + {1'b0, cfg[a].min};
         s1_in.v  = in_raw[a];
         s1_in.mx = cfg[a].max;
         s1_in.mn = cfg[a].min;
         s1_in.c  = (cfg[a].center == '0) ? sum1[DATA_W:1] : cfg[a].center;
      end

      // stage 2: distances from center to the limits, as sign and magnitude
      always_comb begin
         dh2      = {1'b0, s1_ff.mx} - {1'b0, s1_ff.c};
         dl2      = {1'b0, s1_ff.c} - {1'b0, s1_ff.mn};
         s2_in.v  = s1_ff.v;
         s2_in.c  = s1_ff.c;
         s2_in.mx = s1_ff.mx;
         s2_in.mn = s1_ff.mn;
         s2_in.nh = dh2[DATA_W];
         s2_in.nl = dl2[DATA_W];
         s2_in.ah = dh2[DATA_W] ? DATA_W'(-dh2) : dh2[DATA_W-1:0];
         s2_in.al = dl2[DATA_W] ? DATA_W'(-dl2) : dl2[DATA_W-1:0];
      end

      // stage 3: one percent of each distance by reciprocal multiply
      always_comb begin
         ph3      = PROD_W'(s2_ff.ah) * PROD_W'(RECIP_100);
         pl3      = PROD_W'(s2_ff.al) * PROD_W'(RECIP_100);
         s3_in.v  = s2_ff.v;
         s3_in.c  = s2_ff.c;
         s3_in.mx = s2_ff.mx;
         s3_in.mn = s2_ff.mn;
         s3_in.nh = s2_ff.nh;
         s3_in.nl = s2_ff.nl;
         s3_in.qh = Q100_W'(ph3 >> RECIP_SHIFT);
         s3_in.ql = Q100_W'(pl3 >> RECIP_SHIFT);
      end

      // stage 4: derate max and min toward the center
      always_comb begin
         hi4 = s3_ff.nh ? ({1'b0, s3_ff.mx} + (DATA_W + 1)'(s3_ff.qh))
                        : ({1'b0, s3_ff.mx} - (DATA_W + 1)'(s3_ff.qh));
         lo4 = s3_ff.nl ? ({1'b0, s3_ff.mn} - (DATA_W + 1)'(s3_ff.ql))
                        : ({1'b0, s3_ff.mn} + (DATA_W + 1)'(s3_ff.ql));
         s4_in.v  = s3_ff.v;
         s4_in.c  = s3_ff.c;
         s4_in.hi = hi4[DATA_W-1:0];
         s4_in.lo = lo4[DATA_W-1:0];
      end

      // stage 5: pick the side, signed span and distance from center
      always_comb begin
         s5_in.up = (s4_ff.v >= s4_ff.c);
         s5_in.eq = (s4_ff.v == s4_ff.c);
         if (s5_in.up) begin
            s5_in.den  = {1'b0, s4_ff.hi} - {1'b0, s4_ff.c};
            s5_in.diff = s4_ff.v - s4_ff.c;
         end else begin
            s5_in.den  = {1'b0, s4_ff.c} - {1'b0, s4_ff.lo};
            s5_in.diff = s4_ff.c - s4_ff.v;
         end
      end

      // divider setup: numerator is distance times half scale
      always_comb begin
         dv_in[0].rem  = '0;
         dv_in[0].quo  = '0;
         dv_in[0].num  = DIV_W'(s5_ff.diff) * DIV_W'(HALF);
         dv_in[0].dneg = s5_ff.den[DATA_W];
         dv_in[0].dz   = (s5_ff.den == '0);
         dv_in[0].dmag = s5_ff.den[DATA_W] ? DATA_W'(-s5_ff.den) : s5_ff.den[DATA_W-1:0];
         dv_in[0].up   = s5_ff.up;
         dv_in[0].eq   = s5_ff.eq;
      end

      // restoring divider, one quotient bit per stage
      for (genvar k = 1; k <= DIV_W; k++) begin : g_div
         logic [DATA_W:0] sh;
         logic [DATA_W:0] sub;
         logic            ge;

         always_comb begin
            sh  = {dv_ff[k-1].rem, dv_ff[k-1].num[DIV_W-1]};
            sub = sh - {1'b0, dv_ff[k-1].dmag};
            ge  = (sh >= {1'b0, dv_ff[k-1].dmag});
            dv_in[k]      = dv_ff[k-1];
            dv_in[k].rem  = ge ? sub[DATA_W-1:0] : sh[DATA_W-1:0];
            dv_in[k].num  = dv_ff[k-1].num << 1;
            dv_in[k].quo  = {dv_ff[k-1].quo[DIV_W-2:0], ge};
         end
      end

      // result: apply quotient around the midpoint, clamp, zero span cases
      always_comb begin
         neg_r = (!dv_ff[DIV_W].up) ^ dv_ff[DIV_W].dneg;
         val_r = neg_r ? (RES_W'(HALF) - RES_W'(dv_ff[DIV_W].quo))
                       : (RES_W'(HALF) + RES_W'(dv_ff[DIV_W].quo));
         if (val_r > $signed(RES_W'(FULL_SCALE))) begin
            clip_r = RES_W'(FULL_SCALE);
         end else if (val_r < $signed(RES_W'(OUT_FLOOR))) begin
            clip_r = RES_W'(OUT_FLOOR);
         end else begin
            clip_r = val_r;
         end
         if (dv_ff[DIV_W].dz) begin
            if (dv_ff[DIV_W].up) begin
               sel_r = dv_ff[DIV_W].eq ? RES_W'(HALF) : RES_W'(FULL_SCALE);
            end else begin
               sel_r = RES_W'(OUT_FLOOR);
            end
         end else begin
            sel_r = clip_r;
         end
         res_in = sel_r[DATA_W-1:0];
      end

      // stage registers, payload only
      always_ff @(posedge clock) begin
         if (en) begin
            s1_ff  <= s1_in;
            s2_ff  <= s2_in;
            s3_ff  <= s3_in;
            s4_ff  <= s4_in;
            s5_ff  <= s5_in;
            res_ff <= res_in;
         end
      end

      for (genvar k = 0; k <= DIV_W; k++) begin : g_dreg
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[k] <= dv_in[k];
            end
         end
      end

      assign out_norm[a] = res_ff;
   end

endmodule

// ----- src/jcc_checker.sv -----
// jcc_checker: port-level assertions for joystick_center_calibrate_unit
// depends on jcc_pkg; bound to the top level at the end of this file
module jcc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [jcc_pkg::DATA_W-1:0]    rsp_x_norm,
   input logic [jcc_pkg::DATA_W-1:0]    rsp_y_norm
);
   import jcc_pkg::*;

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output or skid not empty after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_norm) && $stable(rsp_y_norm)))
      else $error("stalled response changed");

   // back pressure starts only behind a stalled response
   a_stall_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall rose without a stalled response");

   // back pressure ends only when a response is taken
   a_stall_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> ($past(reset) || $past(rsp_valid && !rsp_stall)))
      else $error("request stall fell without a response taken");

endmodule

bind joystick_center_calibrate_unit jcc_checker u_jcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_x_norm (rsp_x_norm),
   .rsp_y_norm (rsp_y_norm)
);
